[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each macro expects the enclosing module
// to have ports named clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// A condition that implies another in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that implies another in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/mctg_pkg.sv]
// ----------------------------------------------------------------------------
// MIDI clock and timecode generator package
// Shared codes, byte values and the result word passed between the
// event engine and the output buffer.
// ----------------------------------------------------------------------------
package mctg_pkg;

	// Input action codes.
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_PLAY = 2'd1;
	localparam logic [1:0] ACT_STOP = 2'd2;

	// MIDI real-time and system common bytes.
	localparam logic [7:0] BYTE_CLOCK = 8'hF8;
	localparam logic [7:0] BYTE_START = 8'hFA;
	localparam logic [7:0] BYTE_STOP  = 8'hFC;
	localparam logic [7:0] BYTE_QF    = 8'hF1;
	localparam logic [3:0] RATE_24FPS = 4'h0;

	// Playhead limits at 24 fps.
	localparam logic [4:0] FRAMES_PER_SEC = 5'd24;
	localparam logic [4:0] FRAME_STEP     = 5'd2;
	localparam logic [5:0] SECS_PER_MIN   = 6'd60;
	localparam logic [5:0] MINS_PER_HOUR  = 6'd60;
	localparam logic [4:0] HOURS_PER_DAY  = 5'd24;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_START,
		EV_STOP
	} event_t;

	// Bytes produced by one event: count is 0, 1 or 2.
	typedef struct packed {
		logic [1:0] count;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} result_t;

endpackage

[hdl/mctg_core.sv]
// ----------------------------------------------------------------------------
// MIDI clock and timecode event engine
// Holds the transport, hold-off and playhead state and turns one event into
// zero, one or two MIDI bytes combinationally.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mctg_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [1:0]        action,
	input  logic [31:0]       now_ms,
	input  logic              use_timecode,
	output mctg_pkg::result_t result
);
	import mctg_pkg::*;

	event_t      pending_q, pending_d;
	logic        holdoff_q, holdoff_d;
	logic [31:0] holdoff_start_q, holdoff_start_d;
	logic [2:0]  qf_index_q, qf_index_d;
	logic [4:0]  frame_q, frame_d;
	logic [5:0]  second_q, second_d;
	logic [5:0]  minute_q, minute_d;
	logic [4:0]  hour_q, hour_d;

	// Playhead as seen by this tick (cleared by a pending Start).
	logic [4:0]  frame_b;
	logic [5:0]  second_b;
	logic [5:0]  minute_b;
	logic [4:0]  hour_b;
	logic [2:0]  index_b;
	logic [4:0]  frame_sum;
	logic        carry_s, carry_m, carry_h;
	logic        holdoff_live;
	logic [3:0]  nibble;

	always_comb begin
		frame_b  = frame_q;
		second_b = second_q;
		minute_b = minute_q;
		hour_b   = hour_q;
		index_b  = qf_index_q;
		if (pending_q == EV_START) begin
			frame_b  = '0;
			second_b = '0;
			minute_b = '0;
			hour_b   = '0;
			index_b  = '0;
		end
	end

	always_comb begin
		case (index_b)
			3'd0:    nibble = frame_b[3:0];
			3'd1:    nibble = {3'b000, frame_b[4]};
			3'd2:    nibble = second_b[3:0];
			3'd3:    nibble = {2'b00, second_b[5:4]};
			3'd4:    nibble = minute_b[3:0];
			3'd5:    nibble = {2'b00, minute_b[5:4]};
			3'd6:    nibble = hour_b[3:0];
			default: nibble = {3'b000, hour_b[4]} | RATE_24FPS;
		endcase
	end

	// Frames only ever move in steps of two from zero, so the sum tops out at 24.
	assign frame_sum = frame_b + FRAME_STEP;
	assign carry_s   = (frame_sum >= FRAMES_PER_SEC);
	assign carry_m   = carry_s && (second_b == SECS_PER_MIN - 6'd1);
	assign carry_h   = carry_m && (minute_b == MINS_PER_HOUR - 6'd1);

	// A running hold-off survives only while the millisecond time is unchanged.
	assign holdoff_live = holdoff_q && (now_ms == holdoff_start_q);

	always_comb begin
		pending_d       = pending_q;
		holdoff_d       = holdoff_q;
		holdoff_start_d = holdoff_start_q;
		qf_index_d      = qf_index_q;
		frame_d         = frame_q;
		second_d        = second_q;
		minute_d        = minute_q;
		hour_d          = hour_q;
		result          = '{count: 2'd0, byte0: BYTE_CLOCK, byte1: BYTE_CLOCK};
		case (action)
			ACT_PLAY: begin
				pending_d = EV_START;
			end
			ACT_STOP: begin
				pending_d = EV_STOP;
			end
			ACT_TICK: begin
				if (!use_timecode) begin
					if (pending_q != EV_NONE) begin
						result.count    = 2'd1;
						result.byte0    = (pending_q == EV_STOP) ? BYTE_STOP : BYTE_START;
						holdoff_d       = 1'b1;
						holdoff_start_d = now_ms;
						pending_d       = EV_NONE;
					end else begin
						holdoff_d = holdoff_live;
						if (!holdoff_live) begin
							result.count = 2'd1;
						end
					end
				end else if (pending_q != EV_STOP) begin
					pending_d    = EV_NONE;
					result.count = 2'd2;
					result.byte0 = BYTE_QF;
					result.byte1 = {1'b0, index_b, nibble};
					qf_index_d   = index_b + 3'd1;
					frame_d      = frame_b;
					second_d     = second_b;
					minute_d     = minute_b;
					hour_d       = hour_b;
					if (index_b == 3'd7) begin
						frame_d = carry_s ? frame_sum - FRAMES_PER_SEC : frame_sum;
						if (carry_s) begin
							second_d = carry_m ? 6'd0 : second_b + 6'd1;
						end
						if (carry_m) begin
							minute_d = carry_h ? 6'd0 : minute_b + 6'd1;
						end
						if (carry_h) begin
							hour_d = (hour_b == HOURS_PER_DAY - 5'd1) ? 5'd0 : hour_b + 5'd1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q       <= EV_NONE;
			holdoff_q       <= 1'b0;
			holdoff_start_q <= '0;
			qf_index_q      <= '0;
			frame_q         <= '0;
			second_q        <= '0;
			minute_q        <= '0;
			hour_q          <= '0;
		end else if (fire) begin
			pending_q       <= pending_d;
			holdoff_q       <= holdoff_d;
			holdoff_start_q <= holdoff_start_d;
			qf_index_q      <= qf_index_d;
			frame_q         <= frame_d;
			second_q        <= second_d;
			minute_q        <= minute_d;
			hour_q          <= hour_d;
		end
	end

	`ASSERT_ALWAYS(frame_in_range, (frame_q < FRAMES_PER_SEC) && !frame_q[0], "frame count out of range")
	`ASSERT_ALWAYS(time_in_range, (second_q < SECS_PER_MIN) && (minute_q < MINS_PER_HOUR) && (hour_q < HOURS_PER_DAY), "playhead field out of range")
	`ASSERT_NEXT(transport_starts_holdoff, fire && (action == ACT_TICK) && !use_timecode && (pending_q != EV_NONE), holdoff_q && (pending_q == EV_NONE), "transport byte did not start a hold-off")

endmodule

[hdl/mctg_obuf.sv]
// ----------------------------------------------------------------------------
// MIDI clock and timecode output buffer
// Holds the bytes of one event and hands them out one word at a time,
// taking the next event when empty or as its last byte leaves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mctg_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mctg_pkg::result_t result,
	output logic              ready,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        midi_byte,
	output logic              last
);
	import mctg_pkg::*;

	logic [1:0] cnt_q;
	logic [7:0] head_q;
	logic [7:0] tail_q;
	logic       last_q;
	logic       pop;
	logic       store;

	assign out_valid = (cnt_q != 2'd0);
	assign midi_byte = head_q;
	assign last      = last_q;
	assign pop       = out_valid && !out_stall;
	assign ready     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign store     = load && (result.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (store) begin
			cnt_q <= result.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			head_q <= result.byte0;
			tail_q <= result.byte1;
			last_q <= (result.count == 2'd1);
		end else if (pop && (cnt_q == 2'd2)) begin
			head_q <= tail_q;
			last_q <= 1'b1;
		end
	end

	`ASSERT_SAME(load_when_ready, load, ready, "event loaded while buffer busy")
	`ASSERT_SAME(first_of_pair_not_last, cnt_q == 2'd2, !last_q, "first byte of a pair marked last")
	`ASSERT_NEXT(pair_advances, pop && (cnt_q == 2'd2), out_valid && last_q && (cnt_q == 2'd1), "second byte of a pair lost")

endmodule

[hdl/midi_clock_and_timecode_generator_unit.sv]
// ----------------------------------------------------------------------------
// MIDI clock and timecode generator
// Turns play, stop and timer-tick events into MIDI timing clock bytes or
// MTC quarter-frame pairs.
// ----------------------------------------------------------------------------
// An event is captured in an input register and processed when the output
// buffer is free or is giving up its last byte. Play, stop and clock-mode
// ticks produce at most one byte and are taken one per cycle while the output
// is not stalled; a timecode tick produces a two-byte pair unless a Stop is
// pending, sent one byte per cycle, and the next event waits in the input
// register until the pair's last byte leaves. Output stalls propagate back to
// the input stall. The mode register may be written at any time the block is
// idle; its ready is always high.
module midi_clock_and_timecode_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  midi_byte,
	output logic        last
);
	import mctg_pkg::*;

	logic        use_timecode_q;
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [31:0] now_ms_s1;
	logic        buf_ready;
	logic        advance;
	logic        accept;
	result_t     result;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && buf_ready;
	assign in_stall  = valid_s1 && !buf_ready;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_timecode_q <= 1'b0;
			valid_s1       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				use_timecode_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			now_ms_s1 <= now_ms;
		end
	end

	mctg_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.action       (action_s1),
		.now_ms       (now_ms_s1),
		.use_timecode (use_timecode_q),
		.result       (result)
	);

	mctg_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.ready     (buf_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.midi_byte (midi_byte),
		.last      (last)
	);

endmodule

[sim/tb_midi_clock_and_timecode_generator_unit.sv]
// ----------------------------------------------------------------------------
// Testbench for the MIDI clock and timecode generator
// A short table of events is walked first, with expected bytes written in
// where they are obvious. Random play, stop and tick events follow in both
// modes, with a quarter-frame run at the end that carries the playhead
// past a full second. Every byte is checked against a model of the block
// kept in this file, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb_midi_clock_and_timecode_generator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mctg_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD = 120;
	localparam int NROWS = 29;

	typedef enum logic [1:0] {
		ROW_EVENT,
		ROW_MODE
	} row_kind_t;

	// For a mode row, bit 0 of ms holds the value written to the register.
	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  act;
		logic [31:0] ms;
		logic        typed;
		logic [1:0]  n;
		logic [7:0]  b0;
		logic [7:0]  b1;
	} script_row_t;

	typedef struct packed {
		logic [7:0] midi;
		logic       fin;
	} midi_word_t;

	localparam script_row_t SCRIPT [0:NROWS-1] = '{
		'{ROW_MODE,  ACT_TICK,   32'd0,         1'b0, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd1, BYTE_CLOCK, 8'h00},
		'{ROW_EVENT, ACT_PLAY,   32'd0,         1'b1, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_TICK,   32'd5,         1'b1, 2'd1, BYTE_START, 8'h00},
		'{ROW_EVENT, ACT_TICK,   32'd5,         1'b1, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_TICK,   32'd6,         1'b1, 2'd1, BYTE_CLOCK, 8'h00},
		'{ROW_EVENT, ACT_STOP,   32'd0,         1'b1, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_TICK,   32'hFFFF_FFFF, 1'b1, 2'd1, BYTE_STOP,  8'h00},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd1, BYTE_CLOCK, 8'h00},
		'{ROW_EVENT, ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_PLAY,   32'd0,         1'b1, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_STOP,   32'd0,         1'b1, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_TICK,   32'd10,        1'b1, 2'd1, BYTE_STOP,  8'h00},
		'{ROW_EVENT, ACT_PLAY,   32'd0,         1'b1, 2'd0, 8'h00,      8'h00},
		'{ROW_MODE,  ACT_TICK,   32'd1,         1'b0, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_TICK,   32'hFFFF_FFFF, 1'b1, 2'd2, BYTE_QF,    8'h00},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd2, BYTE_QF,    8'h10},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd2, BYTE_QF,    8'h20},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd2, BYTE_QF,    8'h30},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd2, BYTE_QF,    8'h40},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd2, BYTE_QF,    8'h50},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd2, BYTE_QF,    8'h60},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd2, BYTE_QF,    8'h70},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd2, BYTE_QF,    8'h02},
		'{ROW_EVENT, ACT_STOP,   32'd0,         1'b1, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_PLAY,   32'd0,         1'b1, 2'd0, 8'h00,      8'h00},
		'{ROW_EVENT, ACT_TICK,   32'd0,         1'b1, 2'd2, BYTE_QF,    8'h00},
		'{ROW_EVENT, ACT_TICK,   32'hFFFF_FFFF, 1'b0, 2'd0, 8'h00,      8'h00}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = ACT_TICK;
	logic [31:0] now_ms = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  midi_byte;
	logic        last;

	// Model state of the block.
	logic        tc_mode = 1'b0;
	event_t      pend = EV_NONE;
	logic        hold_on = 1'b0;
	logic [31:0] hold_ms = 32'd0;
	logic [2:0]  qf_idx = 3'd0;
	logic [4:0]  frames = 5'd0;
	logic [5:0]  secs = 6'd0;
	logic [5:0]  mins = 6'd0;
	logic [4:0]  hours = 5'd0;

	midi_word_t  midi_byte_queue [$];
	midi_word_t  checked_word;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	logic        offering = 1'b0;
	logic        idling_on = 1'b1;
	logic [31:0] clock_ms = 32'd0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int          stall_left = 0;

	midi_clock_and_timecode_generator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.midi_byte (midi_byte),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("midi_clock_and_timecode_generator_unit: mismatch");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Works out the bytes that one accepted event produces and updates the model.
	function automatic void predict_midi_bytes(input logic [1:0] act, input logic [31:0] ms,
			output logic [1:0] n, output logic [7:0] b0, output logic [7:0] b1);
		logic [3:0] nib;
		n = 2'd0;
		b0 = 8'h00;
		b1 = 8'h00;
		case (act)
		ACT_PLAY: pend = EV_START;
		ACT_STOP: pend = EV_STOP;
		ACT_TICK: begin
			if (!tc_mode) begin
				// Any change of the millisecond time, wrap included, ends the hold-off.
				if (hold_on && ms != hold_ms)
					hold_on = 1'b0;
				if (pend != EV_NONE) begin
					b0 = (pend == EV_START) ? BYTE_START : BYTE_STOP;
					n = 2'd1;
					hold_ms = ms;
					hold_on = 1'b1;
					pend = EV_NONE;
				end else if (!hold_on) begin
					b0 = BYTE_CLOCK;
					n = 2'd1;
				end
			end else if (pend != EV_STOP) begin
				if (pend == EV_START) begin
					frames = 5'd0;
					secs = 6'd0;
					mins = 6'd0;
					hours = 5'd0;
					qf_idx = 3'd0;
				end
				pend = EV_NONE;
				case (qf_idx)
				3'd0: nib = frames[3:0];
				3'd1: nib = {3'b000, frames[4]};
				3'd2: nib = secs[3:0];
				3'd3: nib = {2'b00, secs[5:4]};
				3'd4: nib = mins[3:0];
				3'd5: nib = {2'b00, mins[5:4]};
				3'd6: nib = hours[3:0];
				default: nib = {3'b000, hours[4]} | RATE_24FPS;
				endcase
				n = 2'd2;
				b0 = BYTE_QF;
				b1 = {1'b0, qf_idx, nib};
				qf_idx = qf_idx + 3'd1;
				if (qf_idx == 3'd0) begin
					frames = frames + FRAME_STEP;
					if (frames >= FRAMES_PER_SEC) begin
						frames = frames - FRAMES_PER_SEC;
						secs = secs + 6'd1;
					end
					if (secs == SECS_PER_MIN) begin
						secs = 6'd0;
						mins = mins + 6'd1;
					end
					if (mins == MINS_PER_HOUR) begin
						mins = 6'd0;
						hours = hours + 5'd1;
					end
					if (hours == HOURS_PER_DAY)
						hours = 5'd0;
				end
			end
		end
		default: ;
		endcase
	endfunction

	task automatic release_input();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// Offers one event word and queues the bytes it should produce. A typed row
	// replaces the model's bytes with the ones written in the table.
	task automatic offer_event(input logic [1:0] act, input logic [31:0] ms, input logic typed,
			input logic [1:0] tn, input logic [7:0] tb0, input logic [7:0] tb1);
		logic [1:0] n;
		logic [7:0] b0;
		logic [7:0] b1;
		in_valid <= 1'b1;
		offering = 1'b1;
		action <= act;
		now_ms <= ms;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_midi_bytes(act, ms, n, b0, b1);
		if (typed) begin
			n = tn;
			b0 = tb0;
			b1 = tb1;
		end
		if (n == 2'd2) begin
			midi_byte_queue.push_back({b0, 1'b0});
			midi_byte_queue.push_back({b1, 1'b1});
		end else if (n == 2'd1) begin
			midi_byte_queue.push_back({b0, 1'b1});
		end
		if (idling_on && $urandom_range(0, 3) == 0) begin
			release_input();
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	task automatic write_mode(input logic tc);
		release_input();
		while (midi_byte_queue.size() != 0)
			@(posedge clk);
		// Events that give no byte may still be in flight.
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= tc;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tc_mode = tc;
	endtask

	task automatic run_random_events(input int count, input logic with_idle, input logic long_hold);
		logic [1:0]  act;
		logic [31:0] ms;
		int          pick;
		int          step;
		for (int k = 0; k < count; k++) begin
			if (with_idle)
				idling_on = ((k / 50) % 4) != 3;
			pick = $urandom_range(0, 15);
			if (!tc_mode) begin
				act = (pick <= 10) ? ACT_TICK : (pick <= 12) ? ACT_PLAY :
					(pick <= 14) ? ACT_STOP : ACT_UNUSED;
				// Time mostly stands still or moves by one, so hold-offs both last and end.
				step = $urandom_range(0, 9);
				if (step == 9)
					clock_ms = $urandom;
				else if (step >= 6)
					clock_ms = clock_ms + 32'd1;
				ms = clock_ms;
			end else begin
				act = (pick <= 11) ? ACT_TICK : (pick <= 13) ? ACT_PLAY :
					(pick == 14) ? ACT_STOP : ACT_UNUSED;
				ms = $urandom;
			end
			if (long_hold && k == count / 3)
				hold_requests++;
			offer_event(act, ms, 1'b0, 2'd0, 8'h00, 8'h00);
		end
		release_input();
	endtask

	// Output side: random stall bursts, plus long hold-offs on request.
	always @(posedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served++;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (midi_byte_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected word %02h last %0b", midi_byte, last));
			end else begin
				checked_word = midi_byte_queue.pop_front();
				if (midi_byte !== checked_word.midi)
					report_mismatch($sformatf("midi_byte %02h, expected %02h",
						midi_byte, checked_word.midi));
				if (last !== checked_word.fin)
					report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
						last, checked_word.fin, checked_word.midi));
			end
		end
	end

	initial begin
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].kind == ROW_MODE)
				write_mode(SCRIPT[i].ms[0]);
			else
				offer_event(SCRIPT[i].act, SCRIPT[i].ms, SCRIPT[i].typed,
					SCRIPT[i].n, SCRIPT[i].b0, SCRIPT[i].b1);
		end

		write_mode(1'b0);
		run_random_events(300, 1'b1, 1'b1);
		write_mode(1'b1);
		run_random_events(300, 1'b1, 1'b1);
		write_mode(1'b0);
		run_random_events(300, 1'b1, 1'b0);

		idling_on = 1'b0;
		write_mode(1'b1);
		run_random_events(300, 1'b0, 1'b0);

		// From a fresh Start, 96 quarter frames reach one second; run well past it.
		offer_event(ACT_PLAY, $urandom, 1'b0, 2'd0, 8'h00, 8'h00);
		repeat (170)
			offer_event(ACT_TICK, $urandom, 1'b0, 2'd0, 8'h00, 8'h00);
		release_input();

		while (midi_byte_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatch_count == 0)
			$display("midi_clock_and_timecode_generator_unit: match");
		else
			$display("midi_clock_and_timecode_generator_unit: mismatch");
		$finish;
	end

endmodule
